### hdl/ppd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_pkg: shared types and constants of the PWM ppm decoder
// Register map, reset values, status codes and the queue entry format.
// ----------------------------------------------------------------------------
package ppd_pkg;

	localparam int TIME_W    = 32;
	localparam int MARK_W    = 24;
	localparam int SMALL_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int DATA10_W  = 29;  // 32-bit value divided by ten
	localparam int PROD_W    = DATA10_W + SMALL_W;
	localparam int DIV_W     = 21;  // 24-bit span divided by ten
	localparam int PPM_W     = 16;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [CFG_IDX_W-1:0] CFG_HIGH_MARK = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LOW_MARK  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DATA_SPAN = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_CYCLE     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PPM   = 3'd5;

	localparam logic [MARK_W-1:0]  RST_HIGH_MARK = 24'd2000;
	localparam logic [MARK_W-1:0]  RST_LOW_MARK  = 24'd2000;
	localparam logic [MARK_W-1:0]  RST_DATA_SPAN = 24'd1000000;
	localparam logic [MARK_W-1:0]  RST_CYCLE     = 24'd1004000;
	localparam logic [SMALL_W-1:0] RST_TOLERANCE = 16'd100;
	localparam logic [SMALL_W-1:0] RST_MAX_PPM   = 16'd5000;

	typedef enum logic [1:0] {
		STATUS_OK     = 2'd0,
		STATUS_BOUNCE = 2'd1,
		STATUS_TIMING = 2'd2
	} status_t;

	typedef struct packed {
		logic [MARK_W-1:0]  high_mark_us;
		logic [MARK_W-1:0]  low_mark_us;
		logic [MARK_W-1:0]  data_span_us;
		logic [MARK_W-1:0]  cycle_us;
		logic [SMALL_W-1:0] tolerance_us;
		logic [SMALL_W-1:0] max_ppm;
	} cfg_t;

	typedef struct packed {
		status_t             status;
		logic [DATA10_W-1:0] data10;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_flags_t;

	// floor(x / 10) by reciprocal: exact over the whole 32-bit range
	function automatic logic [DATA10_W-1:0] div10(input logic [TIME_W-1:0] x);
		logic [2*TIME_W-1:0] p;
		p = {32'd0, x} * 64'h00000000CCCCCCCD;
		return p[2*TIME_W-1:35];
	endfunction

endpackage

### hdl/ppd_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_if: channel interfaces of the PWM ppm decoder
// Pin edge request channel and result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ppd_edge_if;
	logic                        valid;
	logic                        ready;
	logic                        level;
	logic [ppd_pkg::TIME_W-1:0]  time_us;

	modport source (output valid, output level, output time_us, input ready);
	modport sink   (input valid, input level, input time_us, output ready);
endinterface

interface ppd_result_if;
	logic                        valid;
	logic                        ready;
	logic [1:0]                  status;
	logic [ppd_pkg::PPM_W-1:0]   ppm;

	modport source (output valid, output status, output ppm, input ready);
	modport sink   (input valid, input status, input ppm, output ready);
endinterface

### hdl/ppd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_front: edge classifier
// Tracks the wait/high/low phase, checks timing on a closing rising edge and
// queues a job for every edge that gives a result.
// ----------------------------------------------------------------------------
module ppd_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppd_pkg::cfg_t        cfg,
	ppd_edge_if.sink             pin_edge,
	input  ppd_pkg::q_flags_t    q_flags,
	output logic                 q_push,
	output ppd_pkg::job_t        q_job
);

	typedef enum logic [1:0] {
		PH_WAIT = 2'd0,
		PH_HIGH = 2'd1,
		PH_LOW  = 2'd2
	} phase_t;

	phase_t                       phase_q;
	logic [ppd_pkg::TIME_W-1:0]   cycle_start_q;
	logic [ppd_pkg::TIME_W-1:0]   low_start_q;

	logic                         accept;
	logic [ppd_pkg::TIME_W-1:0]   cyc, hi, lo, data;
	logic                         timing_bad;

	assign pin_edge.ready = !q_flags.full;
	assign accept         = pin_edge.valid && pin_edge.ready;

	always_comb begin
		cyc = pin_edge.time_us - cycle_start_q;
		hi  = low_start_q - cycle_start_q;
		lo  = pin_edge.time_us - low_start_q;
		// bounds without wrap: a mark below the tolerance leaves no lower bound
		timing_bad = (({1'b0, cyc} + 33'(cfg.tolerance_us)) < 33'(cfg.cycle_us))
			|| ({1'b0, cyc} > (33'(cfg.cycle_us) + 33'(cfg.tolerance_us)))
			|| (({1'b0, hi} + 33'(cfg.tolerance_us)) < 33'(cfg.high_mark_us))
			|| (({1'b0, lo} + 33'(cfg.tolerance_us)) < 33'(cfg.low_mark_us));
		data = (hi > 32'(cfg.high_mark_us)) ? hi - 32'(cfg.high_mark_us) : '0;
	end

	always_comb begin
		q_push       = 1'b0;
		q_job.status = ppd_pkg::STATUS_OK;
		q_job.data10 = ppd_pkg::div10(data);
		case (phase_q)
			PH_HIGH: begin
				if (pin_edge.level) begin
					q_push       = accept;
					q_job.status = ppd_pkg::STATUS_BOUNCE;
				end
			end
			PH_LOW: begin
				q_push = accept;
				if (!pin_edge.level) begin
					q_job.status = ppd_pkg::STATUS_BOUNCE;
				end else if (timing_bad) begin
					q_job.status = ppd_pkg::STATUS_TIMING;
				end
			end
			default: begin
				q_push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_WAIT;
			cycle_start_q <= '0;
			low_start_q   <= '0;
		end else if (accept) begin
			case (phase_q)
				PH_HIGH: begin
					if (pin_edge.level) begin
						phase_q <= PH_WAIT;
					end else begin
						low_start_q <= pin_edge.time_us;
						phase_q     <= PH_LOW;
					end
				end
				PH_LOW: begin
					if (!pin_edge.level || timing_bad) begin
						phase_q <= PH_WAIT;
					end else begin
						cycle_start_q <= pin_edge.time_us;
						phase_q       <= PH_HIGH;
					end
				end
				default: begin
					if (pin_edge.level) begin
						cycle_start_q <= pin_edge.time_us;
						phase_q       <= PH_HIGH;
					end else begin
						phase_q <= PH_WAIT;
					end
				end
			endcase
		end
	end

endmodule

### hdl/ppd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_queue: job queue between classifier and ppm unit
// Small circular buffer of jobs; DEPTH of two or more.
// ----------------------------------------------------------------------------
module ppd_queue #(
	parameter int DEPTH = ppd_pkg::QUEUE_DEPTH
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  ppd_pkg::job_t        push_job,
	input  logic                 pop,
	output ppd_pkg::job_t        head_job,
	output ppd_pkg::q_flags_t    flags
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

	ppd_pkg::job_t   mem_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
	logic [CW-1:0]   count_q;

	assign head_job    = mem_q[rd_ptr_q];
	assign flags.full  = (count_q == CW'(DEPTH));
	assign flags.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### hdl/ppd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppd_back: ppm unit and result register
// Scales the data time by max_ppm, divides by span/10 one bit a cycle with a
// saturation check up front, and holds the result until taken.
// ----------------------------------------------------------------------------
module ppd_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ppd_pkg::cfg_t        cfg,
	input  ppd_pkg::job_t        head_job,
	input  ppd_pkg::q_flags_t    q_flags,
	output logic                 q_pop,
	ppd_result_if.source         result
);

	typedef enum logic [1:0] {
		BK_IDLE = 2'd0,
		BK_MUL  = 2'd1,
		BK_SAT  = 2'd2,
		BK_DIV  = 2'd3
	} bk_state_t;

	localparam int STEP_W = $clog2(ppd_pkg::PPM_W);

	bk_state_t                      state_q;
	logic [ppd_pkg::DATA10_W-1:0]   data10_q;
	logic [ppd_pkg::PROD_W-1:0]     prod_q;
	logic [ppd_pkg::DIV_W-1:0]      div_q;
	logic [ppd_pkg::DIV_W-1:0]      rem_q;
	logic [ppd_pkg::PPM_W-1:0]      quo_q;
	logic [STEP_W-1:0]              step_q;
	logic                           out_valid_q;
	logic [1:0]                     out_status_q;
	logic [ppd_pkg::PPM_W-1:0]      out_ppm_q;

	logic                           out_free;
	logic [ppd_pkg::DIV_W-1:0]      span10;
	logic [ppd_pkg::DIV_W:0]        trial;
	logic                           fits;
	logic [ppd_pkg::PPM_W-1:0]      quo_next;
	logic [ppd_pkg::DIV_W-1:0]      rem_next;
	logic [ppd_pkg::DATA10_W-1:0]   span_div;

	assign result.valid  = out_valid_q;
	assign result.status = out_status_q;
	assign result.ppm    = out_ppm_q;

	assign out_free = !out_valid_q || result.ready;
	assign q_pop    = (state_q == BK_IDLE) && !q_flags.empty && out_free;

	always_comb begin
		span_div = ppd_pkg::div10({8'd0, cfg.data_span_us});
		span10   = span_div[ppd_pkg::DIV_W-1:0];
		// restoring step: shift in the next dividend bit
		trial    = {rem_q, quo_q[ppd_pkg::PPM_W-1]};
		fits     = (trial >= {1'b0, div_q});
		rem_next = fits ? ppd_pkg::DIV_W'(trial - {1'b0, div_q})
		                : trial[ppd_pkg::DIV_W-1:0];
		quo_next = {quo_q[ppd_pkg::PPM_W-2:0], fits};
	end

	always_ff @(posedge clk) begin
		case (state_q)
			BK_IDLE: begin
				data10_q <= head_job.data10;
			end
			BK_MUL: begin
				prod_q <= ppd_pkg::PROD_W'(data10_q) * ppd_pkg::PROD_W'(cfg.max_ppm);
				div_q  <= (span10 == '0) ? ppd_pkg::DIV_W'(1) : span10;
			end
			BK_SAT: begin
				rem_q <= prod_q[ppd_pkg::PPM_W +: ppd_pkg::DIV_W];
				quo_q <= prod_q[ppd_pkg::PPM_W-1:0];
			end
			BK_DIV: begin
				rem_q <= rem_next;
				quo_q <= quo_next;
			end
			default: begin
				rem_q <= rem_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= BK_IDLE;
			step_q       <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ppd_pkg::STATUS_OK;
			out_ppm_q    <= '0;
		end else begin
			if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				BK_IDLE: begin
					if (q_pop) begin
						if (head_job.status == ppd_pkg::STATUS_OK) begin
							state_q <= BK_MUL;
						end else begin
							out_valid_q  <= 1'b1;
							out_status_q <= head_job.status;
							out_ppm_q    <= '0;
						end
					end
				end
				BK_MUL: begin
					state_q <= BK_SAT;
				end
				BK_SAT: begin
					// quotient above 16 bits iff prod / 2^16 reaches the divisor
					if (prod_q[ppd_pkg::PROD_W-1:ppd_pkg::PPM_W] >=
					    (ppd_pkg::PROD_W - ppd_pkg::PPM_W)'(div_q)) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ppd_pkg::STATUS_OK;
						out_ppm_q    <= '1;
						state_q      <= BK_IDLE;
					end else begin
						step_q  <= '0;
						state_q <= BK_DIV;
					end
				end
				BK_DIV: begin
					step_q <= step_q + 1'b1;
					if (step_q == STEP_W'(ppd_pkg::PPM_W - 1)) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ppd_pkg::STATUS_OK;
						out_ppm_q    <= quo_next;
						state_q      <= BK_IDLE;
					end
				end
				default: begin
					state_q <= BK_IDLE;
				end
			endcase
		end
	end

endmodule

### hdl/pwm_ppm_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_ppm_decoder: PWM output decoder for a CO2 sensor
// Usage:
//   pin_edge carries one request per pin edge: the new level and a 32-bit
//   microsecond timestamp. result carries status (ok, bounce, timing) and
//   ppm. Edges that only open a cycle or mark the falling edge give no result.
//   Registers are written through cfg_we/cfg_index/cfg_wdata; writing them
//   only while idle is up to the user, as the block does not enforce it.
//   The classifier takes an edge whenever the two-entry job queue has room,
//   so pin_edge.ready only drops with the queue full.
//   The ppm unit takes one job at a time and takes no new job until it is
//   back in idle: an error result reaches the output register in the cycle
//   after acceptance; an ok result passes the multiply, the saturation check
//   and the bit-serial divider, and a saturated one stops after the check.
//   A result stays in the output register while result.ready is low; the
//   queue keeps taking edges until full.
//   Reset clears the phase to waiting, empties the queue and restores the
//   register defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pwm_ppm_decoder #(
	parameter int QUEUE_DEPTH = ppd_pkg::QUEUE_DEPTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [ppd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [ppd_pkg::MARK_W-1:0]      cfg_wdata,
	ppd_edge_if.sink                        pin_edge,
	ppd_result_if.source                    result
);

	ppd_pkg::cfg_t      cfg_q;
	ppd_pkg::q_flags_t  q_flags;
	ppd_pkg::job_t      push_job, head_job;
	logic               q_push, q_pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.high_mark_us <= ppd_pkg::RST_HIGH_MARK;
			cfg_q.low_mark_us  <= ppd_pkg::RST_LOW_MARK;
			cfg_q.data_span_us <= ppd_pkg::RST_DATA_SPAN;
			cfg_q.cycle_us     <= ppd_pkg::RST_CYCLE;
			cfg_q.tolerance_us <= ppd_pkg::RST_TOLERANCE;
			cfg_q.max_ppm      <= ppd_pkg::RST_MAX_PPM;
		end else if (cfg_we) begin
			case (cfg_index)
				ppd_pkg::CFG_HIGH_MARK: cfg_q.high_mark_us <= cfg_wdata;
				ppd_pkg::CFG_LOW_MARK:  cfg_q.low_mark_us  <= cfg_wdata;
				ppd_pkg::CFG_DATA_SPAN: cfg_q.data_span_us <= cfg_wdata;
				ppd_pkg::CFG_CYCLE:     cfg_q.cycle_us     <= cfg_wdata;
				ppd_pkg::CFG_TOLERANCE: begin
					cfg_q.tolerance_us <= cfg_wdata[ppd_pkg::SMALL_W-1:0];
				end
				ppd_pkg::CFG_MAX_PPM: begin
					cfg_q.max_ppm <= cfg_wdata[ppd_pkg::SMALL_W-1:0];
				end
				default: begin
					cfg_q <= cfg_q;
				end
			endcase
		end
	end

	ppd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.pin_edge (pin_edge),
		.q_flags  (q_flags),
		.q_push   (q_push),
		.q_job    (push_job)
	);

	ppd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (q_push),
		.push_job (push_job),
		.pop      (q_pop),
		.head_job (head_job),
		.flags    (q_flags)
	);

	ppd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.head_job (head_job),
		.q_flags  (q_flags),
		.q_pop    (q_pop),
		.result   (result)
	);

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_flags.full)
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_flags.empty)
		else $error("job popped from an empty queue");

	a_err_ppm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && (result.status != ppd_pkg::STATUS_OK)) |-> (result.ppm == '0))
		else $error("error result carries a nonzero ppm");

	a_pop_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> (!result.valid || result.ready))
		else $error("job taken while a result is still held");
`endif

endmodule
